/* hdl/imubc_pkg.sv */
// ----------------------------------------------------------------------------
// imubc_pkg
// Shared widths, reset values, register codes and control types of the IMU
// bias calibration and scaling core.
// ----------------------------------------------------------------------------
package imubc_pkg;

  localparam int NAXES      = 6;
  localparam int IN_W       = 16;
  localparam int BIAS_W     = 24;
  localparam int ACC_OUT_W  = 23;
  localparam int RATE_OUT_W = 21;
  localparam int GAIN_W     = 24;
  localparam int HALF_W     = GAIN_W / 2;
  localparam int CAL_W      = 11;
  localparam int GAIN_FRAC  = 16;

  localparam int IN_TDATA_W  = NAXES * IN_W;
  localparam int OUT_FIELD_W = 3 * ACC_OUT_W + 3 * RATE_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int MAX_CAL_FRAMES_DEF = 1024;
  localparam int BIAS_FRAC_BITS_DEF = 8;

  localparam logic [CAL_W-1:0]  CAL_SAMPLES_RST = CAL_W'(200);
  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST  = GAIN_W'(2570754);
  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST   = GAIN_W'(572229);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC_LO,
    ST_CALC_HI,
    ST_CALC_SUM,
    ST_DELIVER,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_DONE
  } state_t;

  typedef struct packed {
    logic acc;       // add raw sample into the running sum
    logic load;      // capture |raw - bias| and its sign
    logic mul_lo;    // partial product with low gain half
    logic mul_hi;    // partial product with high gain half
    logic fin;       // combine, round, saturate
    logic div_load;  // start bias division
    logic div_step;  // one quotient bit
    logic div_done;  // latch the bias
  } lane_ctrl_t;

endpackage

/* hdl/imu_bias_calibrate_and_scale_core.sv */
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_scale_core
// Six-axis IMU front end: start-up bias calibration, then bias removal and
// gain scaling per axis, six lanes in parallel.
// ----------------------------------------------------------------------------
// Calibration frames: one per cycle. The closing frame with good frames holds
//   in_tready low through the divider load, step and done states, set by the
//   one-bit-per-cycle bias divider in each lane.
// Run frames: out_tvalid rises after states CALC_LO, CALC_HI, CALC_SUM and DELIVER,
//   set by the two-step split gain multiply and output load; in_tready stays low till then.
// Reset (rst_n low, synchronous): registers to defaults, sums, biases, counters cleared.
module imu_bias_calibrate_and_scale_core #(
  parameter int MAX_CAL_FRAMES = imubc_pkg::MAX_CAL_FRAMES_DEF,
  parameter int BIAS_FRAC_BITS = imubc_pkg::BIAS_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
  input  logic [imubc_pkg::IN_TDATA_W-1:0]       in_tdata,
  // read_ok
  input  logic [0:0]                             in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero pad
  output logic [imubc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [imubc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [imubc_pkg::GAIN_W-1:0]           cfg_data
);

  localparam int IN_W     = imubc_pkg::IN_W;
  localparam int CAL_W    = imubc_pkg::CAL_W;
  localparam int GAIN_W   = imubc_pkg::GAIN_W;
  localparam int CNT_W    = $clog2(MAX_CAL_FRAMES + 1);
  localparam int SUM_W    = IN_W + CNT_W;
  localparam int DIV_W    = SUM_W + BIAS_FRAC_BITS + 1;
  localparam int STEP_W   = $clog2(DIV_W);
  localparam int LIM_W    = (CNT_W > CAL_W) ? CNT_W : CAL_W;
  localparam int PAD_W    = imubc_pkg::OUT_TDATA_W - imubc_pkg::OUT_FIELD_W;

  // configuration registers
  logic [CAL_W-1:0]  cal_samples_r;
  logic [GAIN_W-1:0] accel_gain_r;
  logic [GAIN_W-1:0] gyro_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_samples_r <= imubc_pkg::CAL_SAMPLES_RST;
      accel_gain_r  <= imubc_pkg::ACCEL_GAIN_RST;
      gyro_gain_r   <= imubc_pkg::GYRO_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        imubc_pkg::REG_CAL_SAMPLES: cal_samples_r <= cfg_data[CAL_W-1:0];
        imubc_pkg::REG_ACCEL_GAIN:  accel_gain_r  <= cfg_data;
        imubc_pkg::REG_GYRO_GAIN:   gyro_gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // calibration bookkeeping
  logic             calibrating_r;
  logic [CNT_W-1:0] frames_seen_r;
  logic [CNT_W-1:0] good_frames_r;
  logic [CNT_W-1:0] frames_nxt;
  logic [CNT_W-1:0] good_nxt;
  logic [LIM_W-1:0] cal_ext;
  logic [LIM_W-1:0] cal_lim;
  logic             cal_end;
  logic             in_acc;
  logic             read_ok;

  assign in_acc  = in_tvalid && in_tready;
  assign read_ok = in_tuser[0];

  always_comb begin
    cal_ext = LIM_W'(cal_samples_r);
    if (cal_ext == '0) begin
      cal_lim = LIM_W'(1);
    end else if (cal_ext > LIM_W'(MAX_CAL_FRAMES)) begin
      cal_lim = LIM_W'(MAX_CAL_FRAMES);
    end else begin
      cal_lim = cal_ext;
    end
    frames_nxt = frames_seen_r + CNT_W'(1);
    good_nxt   = good_frames_r + CNT_W'(read_ok);
    cal_end    = LIM_W'(frames_nxt) >= cal_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calibrating_r <= 1'b1;
      frames_seen_r <= '0;
      good_frames_r <= '0;
    end else if (in_acc && calibrating_r) begin
      frames_seen_r <= frames_nxt;
      good_frames_r <= good_nxt;
      if (cal_end) begin
        calibrating_r <= 1'b0;
      end
    end
  end

  // sequencer
  imubc_pkg::state_t     state_r;
  imubc_pkg::state_t     state_nxt;
  logic [STEP_W-1:0]     step_r;
  logic                  merge_ready;
  logic                  out_load;
  imubc_pkg::lane_ctrl_t ctrl;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imubc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (calibrating_r) begin
            if (cal_end && good_nxt != '0) begin
              state_nxt = imubc_pkg::ST_DIV_LOAD;
            end
          end else if (read_ok) begin
            state_nxt = imubc_pkg::ST_CALC_LO;
          end
        end
      end
      imubc_pkg::ST_CALC_LO:  state_nxt = imubc_pkg::ST_CALC_HI;
      imubc_pkg::ST_CALC_HI:  state_nxt = imubc_pkg::ST_CALC_SUM;
      imubc_pkg::ST_CALC_SUM: state_nxt = imubc_pkg::ST_DELIVER;
      imubc_pkg::ST_DELIVER: begin
        if (merge_ready) begin
          state_nxt = imubc_pkg::ST_IDLE;
        end
      end
      imubc_pkg::ST_DIV_LOAD: state_nxt = imubc_pkg::ST_DIV_STEP;
      imubc_pkg::ST_DIV_STEP: begin
        if (step_r == STEP_W'(DIV_W - 1)) begin
          state_nxt = imubc_pkg::ST_DIV_DONE;
        end
      end
      imubc_pkg::ST_DIV_DONE: state_nxt = imubc_pkg::ST_IDLE;
      default:                state_nxt = imubc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = state_r == imubc_pkg::ST_IDLE;
    ctrl          = '0;
    ctrl.acc      = in_acc && calibrating_r && read_ok;
    ctrl.load     = in_acc && !calibrating_r;
    ctrl.mul_lo   = state_r == imubc_pkg::ST_CALC_LO;
    ctrl.mul_hi   = state_r == imubc_pkg::ST_CALC_HI;
    ctrl.fin      = state_r == imubc_pkg::ST_CALC_SUM;
    ctrl.div_load = state_r == imubc_pkg::ST_DIV_LOAD;
    ctrl.div_step = state_r == imubc_pkg::ST_DIV_STEP;
    ctrl.div_done = state_r == imubc_pkg::ST_DIV_DONE;
    out_load      = (state_r == imubc_pkg::ST_DELIVER) && merge_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imubc_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.div_load) begin
        step_r <= '0;
      end else if (ctrl.div_step) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // lanes
  logic signed [imubc_pkg::ACC_OUT_W-1:0]  acc_res  [3];
  logic signed [imubc_pkg::RATE_OUT_W-1:0] rate_res [3];

  for (genvar i = 0; i < 3; i++) begin : g_accel
    imubc_lane #(
      .MAX_CAL_FRAMES (MAX_CAL_FRAMES),
      .BIAS_FRAC_BITS (BIAS_FRAC_BITS),
      .OUT_W          (imubc_pkg::ACC_OUT_W)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .raw   (signed'(in_tdata[i*IN_W +: IN_W])),
      .gain  (accel_gain_r),
      .good  (good_frames_r),
      .res   (acc_res[i])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_gyro
    imubc_lane #(
      .MAX_CAL_FRAMES (MAX_CAL_FRAMES),
      .BIAS_FRAC_BITS (BIAS_FRAC_BITS),
      .OUT_W          (imubc_pkg::RATE_OUT_W)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .raw   (signed'(in_tdata[(i+3)*IN_W +: IN_W])),
      .gain  (gyro_gain_r),
      .good  (good_frames_r),
      .res   (rate_res[i])
    );
  end

  logic [imubc_pkg::OUT_TDATA_W-1:0] packed_res;

  assign packed_res = {{PAD_W{1'b0}}, rate_res[2], rate_res[1], rate_res[0],
                       acc_res[2], acc_res[1], acc_res[0]};

  imubc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .data_in    (packed_res),
    .ready      (merge_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // checks
  a_no_result_while_cal: assert property (@(posedge clk) disable iff (!rst_n)
    calibrating_r |-> !out_tvalid)
    else $error("result transfer offered during calibration");

  a_good_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    good_frames_r <= frames_seen_r)
    else $error("good frame count exceeds frames seen");

  a_div_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == imubc_pkg::ST_DIV_STEP) |-> (!calibrating_r && good_frames_r != '0))
    else $error("bias division without finished calibration or good frames");

  a_run_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !calibrating_r && read_ok) |=> (state_r == imubc_pkg::ST_CALC_LO))
    else $error("good run frame did not start the scaling sequence");

endmodule

/* hdl/imubc_lane.sv */
// ----------------------------------------------------------------------------
// imubc_lane
// One axis: calibration sum, bit-serial bias divider and two-step
// bias-removed gain multiply with rounding and saturation.
// ----------------------------------------------------------------------------
module imubc_lane #(
  parameter int MAX_CAL_FRAMES = imubc_pkg::MAX_CAL_FRAMES_DEF,
  parameter int BIAS_FRAC_BITS = imubc_pkg::BIAS_FRAC_BITS_DEF,
  parameter int OUT_W          = imubc_pkg::ACC_OUT_W,
  localparam int CNT_W         = $clog2(MAX_CAL_FRAMES + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  imubc_pkg::lane_ctrl_t             ctrl,
  input  logic signed [imubc_pkg::IN_W-1:0] raw,
  input  logic [imubc_pkg::GAIN_W-1:0]      gain,
  input  logic [CNT_W-1:0]                  good,
  output logic signed [OUT_W-1:0]           res
);

  localparam int IN_W     = imubc_pkg::IN_W;
  localparam int BIAS_W   = imubc_pkg::BIAS_W;
  localparam int HALF_W   = imubc_pkg::HALF_W;
  localparam int GAIN_W   = imubc_pkg::GAIN_W;
  localparam int SUM_W    = IN_W + CNT_W;
  localparam int DIV_W    = SUM_W + BIAS_FRAC_BITS + 1;
  localparam int QX_W     = ((DIV_W > BIAS_W) ? DIV_W : BIAS_W) + 1;
  localparam int RAW_SH_W = IN_W + BIAS_FRAC_BITS;
  localparam int DIFF_W   = ((RAW_SH_W > BIAS_W) ? RAW_SH_W : BIAS_W) + 1;
  localparam int MP_W     = DIFF_W + HALF_W;
  localparam int HI_W     = GAIN_W - HALF_W;
  localparam int PROD_W   = DIFF_W + GAIN_W;
  localparam int SH       = BIAS_FRAC_BITS + imubc_pkg::GAIN_FRAC;

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [BIAS_W-1:0] bias_r;
  logic [CNT_W-1:0]         rem_r;
  logic [DIV_W-1:0]         quo_r;
  logic                     qneg_r;
  logic [DIFF_W-1:0]        mag_r;
  logic                     neg_r;
  logic [MP_W-1:0]          p_lo_r;
  logic [MP_W-1:0]          p_hi_r;
  logic signed [OUT_W-1:0]  res_r;

  // calibration sum and divider
  logic [SUM_W-1:0]  sum_mag;
  logic [DIV_W-1:0]  dividend;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              rem_ge;
  logic [QX_W-1:0]   qx;
  logic [BIAS_W-1:0] bias_nxt;

  always_comb begin
    sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    dividend = (DIV_W'(sum_mag) << BIAS_FRAC_BITS) + DIV_W'(good >> 1);
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    rem_sub  = rem_sh - {1'b0, good};
    rem_ge   = rem_sh >= {1'b0, good};
    qx       = QX_W'(quo_r);
    if (qneg_r) begin
      if (qx > (QX_W'(1) << (BIAS_W - 1))) begin
        bias_nxt = {1'b1, {(BIAS_W-1){1'b0}}};
      end else begin
        bias_nxt = -qx[BIAS_W-1:0];
      end
    end else begin
      if (qx > ((QX_W'(1) << (BIAS_W - 1)) - QX_W'(1))) begin
        bias_nxt = {1'b0, {(BIAS_W-1){1'b1}}};
      end else begin
        bias_nxt = qx[BIAS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      bias_r <= '0;
    end else begin
      if (ctrl.acc) begin
        sum_r <= sum_r + {{(SUM_W-IN_W){raw[IN_W-1]}}, raw};
      end
      if (ctrl.div_done) begin
        bias_r <= bias_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      qneg_r <= sum_r[SUM_W-1];
    end else if (ctrl.div_step) begin
      rem_r <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
    end
  end

  // scaling path
  logic signed [DIFF_W-1:0] diff;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        q;
  logic [OUT_W-1:0]         res_nxt;

  always_comb begin
    diff = ({{(DIFF_W-IN_W){raw[IN_W-1]}}, raw} <<< BIAS_FRAC_BITS)
           - {{(DIFF_W-BIAS_W){bias_r[BIAS_W-1]}}, bias_r};
    prod = PROD_W'(p_lo_r) + (PROD_W'(p_hi_r) << HALF_W);
    q    = (prod + (PROD_W'(1) << (SH - 1))) >> SH;
    if (neg_r) begin
      if (q > (PROD_W'(1) << (OUT_W - 1))) begin
        res_nxt = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        res_nxt = -q[OUT_W-1:0];
      end
    end else begin
      if (q > ((PROD_W'(1) << (OUT_W - 1)) - PROD_W'(1))) begin
        res_nxt = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        res_nxt = q[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      neg_r <= diff[DIFF_W-1];
    end
    if (ctrl.mul_lo) begin
      p_lo_r <= MP_W'(mag_r) * MP_W'(gain[HALF_W-1:0]);
    end
    if (ctrl.mul_hi) begin
      p_hi_r <= MP_W'(mag_r) * MP_W'(gain[GAIN_W-1 -: HI_W]);
    end
    if (ctrl.fin) begin
      res_r <= signed'(res_nxt);
    end
  end

  assign res = res_r;

endmodule

/* hdl/imubc_merge.sv */
// ----------------------------------------------------------------------------
// imubc_merge
// Output register: collects the six lane results into one result transfer
// and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module imubc_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic [imubc_pkg::OUT_TDATA_W-1:0]   data_in,
  output logic                                ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [imubc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic                              valid_r;
  logic [imubc_pkg::OUT_TDATA_W-1:0] data_r;

  assign ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_in;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* dv/imu_bias_calibrate_and_scale_core_test.sv */
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_scale_core_test
// Self-checking bench for the IMU bias calibration and scaling core. A queue-
// fed driver streams six-axis frames, a local model tracks the start-up bias
// calibration and predicts each scaled frame, and a monitor compares every
// output transfer field by field. Gains change between phases, the output
// side stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_bias_calibrate_and_scale_core_test;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 60;     // covers the bias divider on the closing frame
  localparam int FRAC          = imubc_pkg::BIAS_FRAC_BITS_DEF;
  localparam logic [imubc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic            ok;
    logic [5:0][15:0] raw;   // accel x,y,z then gyro x,y,z, x lowest
  } imu_frame_t;

  typedef struct packed {
    logic [2:0][imubc_pkg::RATE_OUT_W-1:0] rate;
    logic [2:0][imubc_pkg::ACC_OUT_W-1:0]  accel;   // accel x in the lowest bits
  } imu_motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [imubc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]                        in_tuser = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [imubc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [imubc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [imubc_pkg::GAIN_W-1:0]      cfg_data = '0;

  imu_bias_calibrate_and_scale_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // model state
  logic [imubc_pkg::CAL_W-1:0]         m_cal_samples;
  logic [imubc_pkg::GAIN_W-1:0]        m_accel_gain;
  logic [imubc_pkg::GAIN_W-1:0]        m_gyro_gain;
  logic                                m_calibrating;
  logic [imubc_pkg::CAL_W-1:0]         m_frames_seen;
  logic [imubc_pkg::CAL_W-1:0]         m_good_frames;
  logic signed [26:0]                  m_axis_sum [imubc_pkg::NAXES];
  logic signed [imubc_pkg::BIAS_W-1:0] m_axis_bias [imubc_pkg::NAXES];

  imu_frame_t  pending_frames[$];
  imu_motion_t expected_motion[$];
  imu_frame_t  cur_frame;
  imu_motion_t got_motion, want_motion;
  int unsigned frames_queued = 0;
  int unsigned frames_taken = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 0;
  bit          quiet = 0;

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void model_reset();
    m_cal_samples = imubc_pkg::CAL_SAMPLES_RST;
    m_accel_gain  = imubc_pkg::ACCEL_GAIN_RST;
    m_gyro_gain   = imubc_pkg::GYRO_GAIN_RST;
    m_calibrating = 1'b1;
    m_frames_seen = '0;
    m_good_frames = '0;
    for (int i = 0; i < imubc_pkg::NAXES; i++) begin
      m_axis_sum[i]  = '0;
      m_axis_bias[i] = '0;
    end
  endfunction

  function automatic void model_write(logic [imubc_pkg::CFG_IDX_W-1:0] idx,
                                      logic [imubc_pkg::GAIN_W-1:0] val);
    case (idx)
      imubc_pkg::REG_CAL_SAMPLES: m_cal_samples = val[imubc_pkg::CAL_W-1:0];
      imubc_pkg::REG_ACCEL_GAIN:  m_accel_gain  = val;
      imubc_pkg::REG_GYRO_GAIN:   m_gyro_gain   = val;
      default: ;
    endcase
  endfunction

  // rounded mean of the summed samples, Q8
  function automatic logic signed [imubc_pkg::BIAS_W-1:0] mean_bias(
      logic signed [26:0] sum, logic [imubc_pkg::CAL_W-1:0] n);
    longint num;
    longint unsigned mag, q;
    num = longint'(sum) * (longint'(1) <<< FRAC);
    mag = (num < 0) ? -num : num;
    q = (mag + n / 2) / n;
    return imubc_pkg::BIAS_W'(clip((num < 0) ? -longint'(q) : longint'(q),
                                   imubc_pkg::BIAS_W));
  endfunction

  function automatic longint scaled_axis(logic signed [15:0] raw,
                                         logic signed [imubc_pkg::BIAS_W-1:0] bias,
                                         logic [imubc_pkg::GAIN_W-1:0] gain, int w);
    longint diff;
    longint unsigned mag, q;
    diff = (longint'(raw) <<< FRAC) - longint'(bias);
    mag = (diff < 0) ? -diff : diff;
    q = (mag * longint'(gain) + (longint'(1) <<< (FRAC + imubc_pkg::GAIN_FRAC - 1))) >>
        (FRAC + imubc_pkg::GAIN_FRAC);
    return clip((diff < 0) ? -longint'(q) : longint'(q), w);
  endfunction

  function automatic void predict_motion(imu_frame_t f);
    imu_motion_t e;
    int unsigned lim;
    if (m_calibrating) begin
      if (f.ok) begin
        for (int i = 0; i < imubc_pkg::NAXES; i++)
          m_axis_sum[i] = m_axis_sum[i] + $signed(f.raw[i]);
        m_good_frames = m_good_frames + 1'b1;
      end
      m_frames_seen = m_frames_seen + 1'b1;
      lim = (m_cal_samples == 0) ? 1 : m_cal_samples;
      if (lim > imubc_pkg::MAX_CAL_FRAMES_DEF) lim = imubc_pkg::MAX_CAL_FRAMES_DEF;
      if (m_frames_seen >= lim) begin
        if (m_good_frames != 0)
          for (int i = 0; i < imubc_pkg::NAXES; i++)
            m_axis_bias[i] = mean_bias(m_axis_sum[i], m_good_frames);
        m_calibrating = 1'b0;
      end
      return;
    end
    if (!f.ok) return;
    for (int i = 0; i < 3; i++) begin
      e.accel[i] = imubc_pkg::ACC_OUT_W'(scaled_axis($signed(f.raw[i]), m_axis_bias[i],
                                                     m_accel_gain, imubc_pkg::ACC_OUT_W));
      e.rate[i] = imubc_pkg::RATE_OUT_W'(scaled_axis($signed(f.raw[i+3]), m_axis_bias[i+3],
                                                     m_gyro_gain, imubc_pkg::RATE_OUT_W));
    end
    expected_motion.push_back(e);
  endfunction

  function automatic void report_error(string what, longint want, longint got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_motion(cur_frame);
        frames_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          cur_frame = pending_frames.pop_front();
          in_tdata  <= cur_frame.raw;
          in_tuser  <= cur_frame.ok;
          in_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stall bursts, one long hold once results are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_motion = imu_motion_t'(out_tdata[imubc_pkg::OUT_FIELD_W-1:0]);
      results_seen++;
      if (expected_motion.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result transfer %h", out_tdata);
      end else begin
        want_motion = expected_motion.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got_motion.accel[i] !== want_motion.accel[i])
            report_error($sformatf("accel[%0d]", i), $signed(want_motion.accel[i]),
                         $signed(got_motion.accel[i]));
          if (got_motion.rate[i] !== want_motion.rate[i])
            report_error($sformatf("rate[%0d]", i), $signed(want_motion.rate[i]),
                         $signed(got_motion.rate[i]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // leaves cfg_valid high; caller drops it after the last write of a batch
  task automatic write_reg(logic [imubc_pkg::CFG_IDX_W-1:0] idx,
                           logic [imubc_pkg::GAIN_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, val);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (frames_taken != frames_queued || expected_motion.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_frame(imu_frame_t f);
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  function automatic imu_frame_t flat_frame(logic [15:0] v, logic ok);
    imu_frame_t f;
    for (int i = 0; i < imubc_pkg::NAXES; i++) f.raw[i] = v;
    f.ok = ok;
    return f;
  endfunction

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic imu_frame_t random_frame(int unsigned ok_pct);
    imu_frame_t f;
    for (int i = 0; i < imubc_pkg::NAXES; i++) f.raw[i] = pick_raw();
    f.ok = ($urandom_range(0, 99) < ok_pct);
    return f;
  endfunction

  function automatic logic [imubc_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return imubc_pkg::GAIN_W'($urandom_range(0, 1 << 20));
      default: return imubc_pkg::GAIN_W'($urandom());
    endcase
  endfunction

  task automatic queue_random(int unsigned n, int unsigned ok_pct);
    for (int i = 0; i < n; i++) push_frame(random_frame(ok_pct));
  endtask

  task automatic new_gains(logic [imubc_pkg::GAIN_W-1:0] acc,
                           logic [imubc_pkg::GAIN_W-1:0] gyr);
    write_reg(imubc_pkg::REG_ACCEL_GAIN, acc);
    write_reg(imubc_pkg::REG_GYRO_GAIN, gyr);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    imu_frame_t f;
    model_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration length above the maximum, gains at their defaults
    write_reg(imubc_pkg::REG_CAL_SAMPLES, 24'h0007FF);
    write_reg(imubc_pkg::REG_ACCEL_GAIN, imubc_pkg::ACCEL_GAIN_RST);
    write_reg(imubc_pkg::REG_GYRO_GAIN, imubc_pkg::GYRO_GAIN_RST);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    cfg_valid <= 1'b0;

    // calibration frames: extremes, failed reads, random content
    push_frame(flat_frame(16'h7FFF, 1'b1));
    push_frame(flat_frame(16'h8000, 1'b1));
    push_frame(flat_frame(16'h0000, 1'b1));
    push_frame(flat_frame(16'hFFFF, 1'b0));
    f = flat_frame(16'h5555, 1'b0);
    f.raw[1] = 16'hAAAA;
    f.raw[3] = 16'hAAAA;
    f.raw[5] = 16'hAAAA;
    push_frame(f);
    for (int i = 0; i < 5; i++) push_frame(random_frame(100));
    for (int i = 0; i < 2; i++) push_frame(random_frame(0));
    wait_drained();

    // length cut to zero (upper data bits dropped): already past, so the next frame closes
    write_reg(imubc_pkg::REG_CAL_SAMPLES, 24'hFFF800);
    cfg_valid <= 1'b0;
    push_frame(random_frame(100));

    // first run frames at default gains
    push_frame(flat_frame(16'h7FFF, 1'b1));
    push_frame(flat_frame(16'h8000, 1'b1));
    push_frame(flat_frame(16'h0000, 1'b1));
    push_frame(flat_frame(16'h7FFF, 1'b0));
    f = flat_frame(16'h7FFF, 1'b1);
    for (int i = 3; i < imubc_pkg::NAXES; i++) f.raw[i] = 16'h8000;
    push_frame(f);
    for (int i = 0; i < 3; i++) push_frame(random_frame(100));
    queue_random(100, 85);
    wait_drained();

    // gain extremes; calibration length writes no longer matter
    write_reg(imubc_pkg::REG_CAL_SAMPLES, 24'd1024);
    write_reg(REG_UNUSED, 24'h000000);
    new_gains(24'h000000, 24'hFFFFFF);
    queue_random(90, 85);
    wait_drained();

    new_gains(24'hFFFFFF, 24'h000000);
    queue_random(90, 85);
    wait_drained();

    for (int p = 0; p < 2; p++) begin
      new_gains(pick_gain(), pick_gain());
      queue_random(90, 80);
      wait_drained();
    end

    // closing stretch without idling on either side
    quiet = 1;
    new_gains(pick_gain(), pick_gain());
    queue_random(70, 90);
    wait_drained();

    if (err_count == 0 && expected_motion.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
